### design/evad_pkg.sv
// ----------------------------------------------------------------------------
// evad_pkg
// Types, register indexes, reset values and end codes shared by the
// energy VAD endpointer modules.
// ----------------------------------------------------------------------------
package evad_pkg;

    // Design defaults
    localparam int MAX_FRAME_DEF   = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SMART_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORD = 3'd4;

    localparam logic        RST_SMART_EN   = 1'b1;
    localparam logic [15:0] RST_VOICE_THR  = 16'd500;
    localparam logic [12:0] RST_SILENCE_MS = 13'd800;
    localparam logic [12:0] RST_MIN_SPEECH = 13'd300;
    localparam logic [19:0] RST_MAX_RECORD = 20'd30000;

    // Command field values
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_START  = 1'b1;

    // End codes
    localparam logic [2:0] END_NONE      = 3'd0;
    localparam logic [2:0] END_SPEECH    = 3'd1;
    localparam logic [2:0] END_TIME      = 3'd2;
    localparam logic [2:0] END_NO_AUDIO  = 3'd3;
    localparam logic [2:0] END_FRAME_LEN = 3'd4;

    typedef struct packed {
        logic               command;
        logic signed [15:0] sample;
        logic               frame_end;
        logic [31:0]        time_ms;
    } evad_in_t;

    typedef struct packed {
        logic       frame_valid;
        logic       frame_voiced;
        logic       turn_active;
        logic [2:0] end_code;
    } evad_out_t;

    // Classified request, front -> back
    typedef struct packed {
        logic        is_start;
        logic        frame_end;
        logic [15:0] mag;
        logic [31:0] time_ms;
    } evad_item_t;

    typedef struct packed {
        logic        smart_en;
        logic [15:0] voice_thr;
        logic [12:0] silence_ms;
        logic [12:0] min_speech_ms;
        logic [19:0] max_record_ms;
    } evad_cfg_t;

endpackage

### design/energy_vad_endpointer.sv
// ----------------------------------------------------------------------------
// energy_vad_endpointer
// Energy based voice activity detector with turn endpointing.
// ----------------------------------------------------------------------------
//  channel   handshake                payload
//  --------  -----------------------  -----------------------------------
//  audio     audio_valid/audio_ready  audio  : command, sample, frame_end, time_ms
//  result    result_valid/result_ready result : frame_valid, frame_voiced,
//                                               turn_active, end_code
//  config    cfg_valid/cfg_ready      cfg_index, cfg_data (always ready)
//
//  One request per cycle sustained unless a stall drops audio_ready; each
//  request gives exactly one result. A request passes through the intake
//  register, the queue and the result register before its result appears;
//  the accumulate/multiply/compare in the endpointing stage is combinational.
//  Reset (rst_n low, async) clears all turn state and loads the default config.
//  The intake and result sides stall independently; the queue absorbs the
//  difference, and audio_ready drops only once intake and queue are both full.
// ----------------------------------------------------------------------------
module energy_vad_endpointer
    import evad_pkg::*;
#(
    parameter int MAX_FRAME   = MAX_FRAME_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  audio_valid,
    output logic                  audio_ready,
    input  evad_in_t              audio,
    output logic                  result_valid,
    input  logic                  result_ready,
    output evad_out_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    evad_cfg_t  cfg_reg, cfg_next;
    logic       push_valid, push_ready;
    evad_item_t push_item;
    logic       pop_valid, pop_ready;
    evad_item_t pop_item;

    // Config registers; writes to unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SMART_EN:   cfg_next.smart_en      = cfg_data[0];
                REG_VOICE_THR:  cfg_next.voice_thr     = cfg_data[15:0];
                REG_SILENCE_MS: cfg_next.silence_ms    = cfg_data[12:0];
                REG_MIN_SPEECH: cfg_next.min_speech_ms = cfg_data[12:0];
                REG_MAX_RECORD: cfg_next.max_record_ms = cfg_data[19:0];
                default:        cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smart_en      <= RST_SMART_EN;
            cfg_reg.voice_thr     <= RST_VOICE_THR;
            cfg_reg.silence_ms    <= RST_SILENCE_MS;
            cfg_reg.min_speech_ms <= RST_MIN_SPEECH;
            cfg_reg.max_record_ms <= RST_MAX_RECORD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: intake and classification
    evad_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .audio_valid (audio_valid),
        .audio_ready (audio_ready),
        .audio       (audio),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    // Decoupling queue
    evad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: endpointing and result register
    evad_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### design/evad_front.sv
// ----------------------------------------------------------------------------
// evad_front
// Intake stage: registers each request, classifies it and takes the sample
// magnitude.
// ----------------------------------------------------------------------------
module evad_front
    import evad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       audio_valid,
    output logic       audio_ready,
    input  evad_in_t   audio,
    output logic       push_valid,
    input  logic       push_ready,
    output evad_item_t push_item
);

    logic       fr_valid_reg, fr_valid_next;
    evad_item_t fr_item_reg, fr_item_next;
    logic       take;
    logic       push;

    assign push        = fr_valid_reg && push_ready;
    assign audio_ready = !fr_valid_reg || push_ready;
    assign take        = audio_valid && audio_ready;
    assign push_valid  = fr_valid_reg;
    assign push_item   = fr_item_reg;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        fr_item_next  = fr_item_reg;
        if (take)
        begin
            fr_valid_next          = 1'b1;
            fr_item_next.is_start  = (audio.command == CMD_START);
            fr_item_next.frame_end = audio.frame_end;
            fr_item_next.time_ms   = audio.time_ms;
            // two's complement magnitude; -32768 gives 0x8000
            fr_item_next.mag       = audio.sample[15] ? (~audio.sample + 16'd1)
                                                      : audio.sample;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_item_reg <= fr_item_next;
    end

endmodule

### design/evad_queue.sv
// ----------------------------------------------------------------------------
// evad_queue
// Small FIFO between the intake stage and the endpointing stage.
// ----------------------------------------------------------------------------
module evad_queue
    import evad_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  evad_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output evad_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    evad_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/evad_back.sv
// ----------------------------------------------------------------------------
// evad_back
// Endpointing stage: frame accumulation, voice decision, turn tracking and
// the registered result.
// ----------------------------------------------------------------------------
module evad_back
    import evad_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  evad_cfg_t  cfg,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  evad_item_t pop_item,
    output logic       result_valid,
    input  logic       result_ready,
    output evad_out_t  result
);

    // count saturates at MAX_FRAME+1; sum holds at most MAX_FRAME * 32768
    localparam int CNT_W  = $clog2(MAX_FRAME + 2);
    localparam int SUM_W  = 15 + $clog2(MAX_FRAME + 1);
    localparam int NEED_W = 16 + CNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

    logic             listening_reg, listening_next;
    logic             speech_seen_reg, speech_seen_next;
    logic             any_audio_reg, any_audio_next;
    logic [31:0]      first_voice_reg, first_voice_next;
    logic [31:0]      last_voice_reg, last_voice_next;
    logic [31:0]      turn_start_reg, turn_start_next;
    logic [SUM_W-1:0] abs_sum_reg, abs_sum_next;
    logic [CNT_W-1:0] frame_count_reg, frame_count_next;
    logic             result_valid_reg, result_valid_next;
    evad_out_t        result_reg, result_next;

    logic              fire;
    logic [CNT_W-1:0]  cnt_inc;
    logic [SUM_W-1:0]  sum_add;
    logic [NEED_W-1:0] need;
    logic [31:0]       since_start, since_first, since_last;
    logic              voiced;

    assign pop_ready    = !result_valid_reg || result_ready;
    assign fire         = pop_valid && pop_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        cnt_inc     = (frame_count_reg <= MAX_CNT) ? frame_count_reg + 1'b1
                                                   : frame_count_reg;
        sum_add     = (frame_count_reg < MAX_CNT) ? abs_sum_reg + SUM_W'(pop_item.mag)
                                                  : abs_sum_reg;
        need        = NEED_W'(cfg.voice_thr) * NEED_W'(cnt_inc);
        voiced      = (NEED_W'(sum_add) >= need);
        since_start = pop_item.time_ms - turn_start_reg;
        since_first = pop_item.time_ms - first_voice_reg;
        since_last  = pop_item.time_ms - last_voice_reg;
    end

    always_comb
    begin
        listening_next    = listening_reg;
        speech_seen_next  = speech_seen_reg;
        any_audio_next    = any_audio_reg;
        first_voice_next  = first_voice_reg;
        last_voice_next   = last_voice_reg;
        turn_start_next   = turn_start_reg;
        abs_sum_next      = abs_sum_reg;
        frame_count_next  = frame_count_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end

        if (fire)
        begin
            result_valid_next = 1'b1;
            result_next       = '0;
            if (pop_item.is_start)
            begin
                // start (or restart) a turn
                listening_next   = 1'b1;
                speech_seen_next = 1'b0;
                any_audio_next   = 1'b0;
                first_voice_next = pop_item.time_ms;
                last_voice_next  = pop_item.time_ms;
                turn_start_next  = pop_item.time_ms;
                abs_sum_next     = '0;
                frame_count_next = '0;
            end
            else if (listening_reg)
            begin
                abs_sum_next     = sum_add;
                frame_count_next = cnt_inc;
                if (pop_item.frame_end)
                begin
                    abs_sum_next     = '0;
                    frame_count_next = '0;
                    if (since_start >= 32'(cfg.max_record_ms))
                    begin
                        result_next.end_code = any_audio_reg ? END_TIME : END_NO_AUDIO;
                        listening_next       = 1'b0;
                    end
                    else if (cnt_inc > MAX_CNT)
                    begin
                        result_next.end_code = END_FRAME_LEN;
                        listening_next       = 1'b0;
                    end
                    else
                    begin
                        any_audio_next = 1'b1;
                        if (cfg.smart_en)
                        begin
                            result_next.frame_valid = 1'b1;
                            if (voiced)
                            begin
                                result_next.frame_voiced = 1'b1;
                                if (!speech_seen_reg)
                                begin
                                    speech_seen_next = 1'b1;
                                    first_voice_next = pop_item.time_ms;
                                end
                                last_voice_next = pop_item.time_ms;
                            end
                            else if (speech_seen_reg &&
                                     since_first >= 32'(cfg.min_speech_ms) &&
                                     since_last >= 32'(cfg.silence_ms))
                            begin
                                result_next.end_code = END_SPEECH;
                                listening_next       = 1'b0;
                            end
                        end
                    end
                end
            end
            result_next.turn_active = listening_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listening_reg    <= 1'b0;
            speech_seen_reg  <= 1'b0;
            any_audio_reg    <= 1'b0;
            first_voice_reg  <= '0;
            last_voice_reg   <= '0;
            turn_start_reg   <= '0;
            abs_sum_reg      <= '0;
            frame_count_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            listening_reg    <= listening_next;
            speech_seen_reg  <= speech_seen_next;
            any_audio_reg    <= any_audio_next;
            first_voice_reg  <= first_voice_next;
            last_voice_reg   <= last_voice_next;
            turn_start_reg   <= turn_start_next;
            abs_sum_reg      <= abs_sum_next;
            frame_count_reg  <= frame_count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

### design/evad_checker.sv
// ----------------------------------------------------------------------------
// evad_checker
// Port level checks on the result channel of the endpointer.
// ----------------------------------------------------------------------------
module evad_checker
    import evad_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_ready,
    input evad_out_t result
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // closing a turn leaves it inactive
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_code != END_NONE |-> !result.turn_active)
        else $error("end code with turn still active");

    a_voiced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_voiced |-> result.frame_valid)
        else $error("voiced without evaluated frame");

    // an evaluated frame either keeps the turn open or ends it on silence
    a_eval: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_valid |->
            (result.end_code == END_NONE && result.turn_active) ||
            (result.end_code == END_SPEECH && !result.frame_voiced))
        else $error("bad outcome for evaluated frame");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.end_code <= END_FRAME_LEN)
        else $error("end code out of range");

endmodule

bind energy_vad_endpointer evad_checker u_evad_checker (.*);
